/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is high
`define APBB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define APBB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/apbb_pkg.sv */
// package: shared types and constants of the affine bounding box block
`default_nettype none

package apbb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int REG_ADDR_W      = 5;
  localparam int FRAC_W          = 16;
  localparam int PROD_W          = 2 * DATA_W;
  localparam int TERM_W          = PROD_W - FRAC_W;
  localparam int SUM_W           = TERM_W + 2;

  typedef enum logic [2:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_D   = 3'd3,
    REG_OFFSET_E = 3'd4,
    REG_OFFSET_F = 3'd5
  } reg_idx_t;

  localparam logic [DATA_W-1:0] COEF_ONE  = DATA_W'(65536);
  localparam logic [DATA_W-1:0] COEF_ZERO = '0;

  typedef struct packed {
    logic [DATA_W-1:0] coef_a;
    logic [DATA_W-1:0] coef_b;
    logic [DATA_W-1:0] coef_c;
    logic [DATA_W-1:0] coef_d;
    logic [DATA_W-1:0] offset_e;
    logic [DATA_W-1:0] offset_f;
  } matrix_t;

endpackage

`default_nettype wire

/* rtl/core/apbb_regs.sv */
// apb register file holding the affine matrix
`default_nettype none

module apbb_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [apbb_pkg::REG_ADDR_W-1:0]   paddr,
  input  wire logic [apbb_pkg::DATA_W-1:0]       pwdata,
  output logic      [apbb_pkg::DATA_W-1:0]       prdata,
  output apbb_pkg::matrix_t                      matrix
);

  apbb_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = apbb_pkg::reg_idx_t'(paddr[apbb_pkg::REG_ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix.coef_a   <= apbb_pkg::COEF_ONE;
      matrix.coef_b   <= apbb_pkg::COEF_ZERO;
      matrix.coef_c   <= apbb_pkg::COEF_ZERO;
      matrix.coef_d   <= apbb_pkg::COEF_ONE;
      matrix.offset_e <= apbb_pkg::COEF_ZERO;
      matrix.offset_f <= apbb_pkg::COEF_ZERO;
    end else if (wr_en) begin
      unique case (idx)
        apbb_pkg::REG_COEF_A:   matrix.coef_a   <= pwdata;
        apbb_pkg::REG_COEF_B:   matrix.coef_b   <= pwdata;
        apbb_pkg::REG_COEF_C:   matrix.coef_c   <= pwdata;
        apbb_pkg::REG_COEF_D:   matrix.coef_d   <= pwdata;
        apbb_pkg::REG_OFFSET_E: matrix.offset_e <= pwdata;
        apbb_pkg::REG_OFFSET_F: matrix.offset_f <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      apbb_pkg::REG_COEF_A:   prdata = matrix.coef_a;
      apbb_pkg::REG_COEF_B:   prdata = matrix.coef_b;
      apbb_pkg::REG_COEF_C:   prdata = matrix.coef_c;
      apbb_pkg::REG_COEF_D:   prdata = matrix.coef_d;
      apbb_pkg::REG_OFFSET_E: prdata = matrix.offset_e;
      apbb_pkg::REG_OFFSET_F: prdata = matrix.offset_f;
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/apbb_xform.sv */
// affine transform pipeline: input register, product register, saturated sum register
`default_nettype none

module apbb_xform #(
  parameter int COORD_WIDTH = apbb_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire apbb_pkg::matrix_t                   matrix,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [apbb_pkg::DATA_W-1:0]  point_x,
  input  wire logic signed [apbb_pkg::DATA_W-1:0]  point_y,
  input  wire logic                                last_point,
  output logic                                     sum_valid,
  input  wire logic                                sum_ready,
  output logic signed [COORD_WIDTH-1:0]            sum_x,
  output logic signed [COORD_WIDTH-1:0]            sum_y,
  output logic                                     sum_last
);

  localparam int SW = apbb_pkg::SUM_W;
  localparam int TW = apbb_pkg::TERM_W;
  localparam int PW = apbb_pkg::PROD_W;
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  // input register
  logic                                pt_valid;
  logic signed [apbb_pkg::DATA_W-1:0]  pt_x;
  logic signed [apbb_pkg::DATA_W-1:0]  pt_y;
  logic                                pt_last;
  logic                                pt_ready;

  // product register, each product already shifted down by the fraction width
  logic                 pr_valid;
  logic signed [TW-1:0] pr_ax;
  logic signed [TW-1:0] pr_cy;
  logic signed [TW-1:0] pr_bx;
  logic signed [TW-1:0] pr_dy;
  logic                 pr_last;
  logic                 pr_ready;

  logic signed [apbb_pkg::DATA_W-1:0] ca, cb, cc, cd, oe, of_;
  logic signed [PW-1:0]               m_ax, m_cy, m_bx, m_dy;
  logic signed [SW-1:0]               s_x, s_y;

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SAT_HI) begin
      return COORD_WIDTH'(SAT_HI);
    end else if (v < SAT_LO) begin
      return COORD_WIDTH'(SAT_LO);
    end
    return COORD_WIDTH'(v);
  endfunction

  assign ca  = matrix.coef_a;
  assign cb  = matrix.coef_b;
  assign cc  = matrix.coef_c;
  assign cd  = matrix.coef_d;
  assign oe  = matrix.offset_e;
  assign of_ = matrix.offset_f;

  // each stage takes a new transaction when empty or when its content moves on
  assign pr_ready = !sum_valid || sum_ready;
  assign pt_ready = !pr_valid || pr_ready;
  assign in_ready = !pt_valid || pt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (in_ready) begin
      pt_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pt_x    <= point_x;
      pt_y    <= point_y;
      pt_last <= last_point;
    end
  end

  assign m_ax = PW'(ca) * PW'(pt_x);
  assign m_cy = PW'(cc) * PW'(pt_y);
  assign m_bx = PW'(cb) * PW'(pt_x);
  assign m_dy = PW'(cd) * PW'(pt_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (pt_ready) begin
      pr_valid <= pt_valid;
    end
  end

  // dropping the low bits is the arithmetic shift, rounding toward minus infinity
  always_ff @(posedge clk) begin
    if (pt_valid && pt_ready) begin
      pr_ax   <= m_ax[PW-1:apbb_pkg::FRAC_W];
      pr_cy   <= m_cy[PW-1:apbb_pkg::FRAC_W];
      pr_bx   <= m_bx[PW-1:apbb_pkg::FRAC_W];
      pr_dy   <= m_dy[PW-1:apbb_pkg::FRAC_W];
      pr_last <= pt_last;
    end
  end

  assign s_x = SW'(pr_ax) + SW'(pr_cy) + SW'(oe);
  assign s_y = SW'(pr_bx) + SW'(pr_dy) + SW'(of_);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (pr_ready) begin
      sum_valid <= pr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pr_valid && pr_ready) begin
      sum_x    <= sat(s_x);
      sum_y    <= sat(s_y);
      sum_last <= pr_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/apbb_track.sv */
// running min/max tracker and result register
`default_nettype none

module apbb_track #(
  parameter int COORD_WIDTH = apbb_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                sum_valid,
  output logic                                     sum_ready,
  input  wire logic signed [COORD_WIDTH-1:0]       sum_x,
  input  wire logic signed [COORD_WIDTH-1:0]       sum_y,
  input  wire logic                                sum_last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [apbb_pkg::DATA_W-1:0]       min_x,
  output logic signed [apbb_pkg::DATA_W-1:0]       min_y,
  output logic signed [apbb_pkg::DATA_W-1:0]       max_x,
  output logic signed [apbb_pkg::DATA_W-1:0]       max_y
);

  localparam int DW = apbb_pkg::DATA_W;

  logic                          seen_any;
  logic signed [COORD_WIDTH-1:0] low_x, low_y, high_x, high_y;
  logic signed [COORD_WIDTH-1:0] low_x_next, low_y_next, high_x_next, high_y_next;
  logic                          take;

  // only a closing point needs the result register free
  assign sum_ready = !sum_last || !out_valid || out_ready;
  assign take      = sum_valid && sum_ready;

  // first point of a set seeds all four; ties keep the stored value
  always_comb begin
    low_x_next  = (!seen_any || sum_x < low_x)  ? sum_x : low_x;
    high_x_next = (!seen_any || sum_x > high_x) ? sum_x : high_x;
    low_y_next  = (!seen_any || sum_y < low_y)  ? sum_y : low_y;
    high_y_next = (!seen_any || sum_y > high_y) ? sum_y : high_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any <= 1'b0;
      low_x    <= '0;
      low_y    <= '0;
      high_x   <= '0;
      high_y   <= '0;
    end else if (take) begin
      if (sum_last) begin
        seen_any <= 1'b0;
        low_x    <= '0;
        low_y    <= '0;
        high_x   <= '0;
        high_y   <= '0;
      end else begin
        seen_any <= 1'b1;
        low_x    <= low_x_next;
        low_y    <= low_y_next;
        high_x   <= high_x_next;
        high_y   <= high_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && sum_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // narrow coordinates sign-extend, wide ones keep their low word
  always_ff @(posedge clk) begin
    if (take && sum_last) begin
      min_x <= DW'(low_x_next);
      min_y <= DW'(low_y_next);
      max_x <= DW'(high_x_next);
      max_y <= DW'(high_y_next);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/affine_point_bounding_box.sv */
// Affine point bounding box: maps each Q16.16 point through a 2x3 matrix
// and reports the box around the mapped points of a set.
//
// Input channel: in_valid/in_ready with point_x, point_y, last_point. A
// transaction with last_point high closes the set; the box of that set,
// including the closing point, leaves on the output channel.
// Output channel: out_valid/out_ready with min_x, min_y, max_x, max_y.
// Matrix registers sit on the apb port at byte offsets 0x00 to 0x14
// (coef_a, coef_b, coef_c, coef_d, offset_e, offset_f); load them while idle.
//
// Throughput: one point per cycle while the pipeline does not stall. The datapath is an input register, a
// product register (four 32x32 multipliers) and a saturated sum register,
// followed by the min/max tracker and its result register.
// A closing point passes the input, product and sum registers, and its box
// is then registered in the result register and shown on the output.
// Stall: while a box waits on out_ready, points that do not close a set keep
// flowing; a second closing point waits in the sum register and backs up the
// pipeline behind it.
// Reset: the matrix returns to identity, the tracker forgets any open set
// and all stages empty.
`default_nettype none

module affine_point_bounding_box #(
  parameter int COORD_WIDTH = apbb_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [apbb_pkg::REG_ADDR_W-1:0]     paddr,
  input  wire logic [apbb_pkg::DATA_W-1:0]         pwdata,
  output logic      [apbb_pkg::DATA_W-1:0]         prdata,
  output logic                                     pready,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [apbb_pkg::DATA_W-1:0]  point_x,
  input  wire logic signed [apbb_pkg::DATA_W-1:0]  point_y,
  input  wire logic                                last_point,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [apbb_pkg::DATA_W-1:0]       min_x,
  output logic signed [apbb_pkg::DATA_W-1:0]       min_y,
  output logic signed [apbb_pkg::DATA_W-1:0]       max_x,
  output logic signed [apbb_pkg::DATA_W-1:0]       max_y
);

  apbb_pkg::matrix_t             matrix;
  logic                          sum_valid;
  logic                          sum_ready;
  logic signed [COORD_WIDTH-1:0] sum_x;
  logic signed [COORD_WIDTH-1:0] sum_y;
  logic                          sum_last;

  assign pready = 1'b1;

  apbb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .matrix  (matrix)
  );

  apbb_xform #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_xform (
    .clk        (clk),
    .rst        (rst),
    .matrix     (matrix),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum_x      (sum_x),
    .sum_y      (sum_y),
    .sum_last   (sum_last)
  );

  apbb_track #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_x     (sum_x),
    .sum_y     (sum_y),
    .sum_last  (sum_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_x     (min_x),
    .min_y     (min_y),
    .max_x     (max_x),
    .max_y     (max_y)
  );

endmodule

`default_nettype wire

/* rtl/core/apbb_checker.sv */
// port-level checker for the affine bounding box, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module apbb_checker #(
  parameter int COORD_WIDTH = apbb_pkg::COORD_WIDTH_DEF
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                pready,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [apbb_pkg::DATA_W-1:0]  min_x,
  input wire logic signed [apbb_pkg::DATA_W-1:0]  min_y,
  input wire logic signed [apbb_pkg::DATA_W-1:0]  max_x,
  input wire logic signed [apbb_pkg::DATA_W-1:0]  max_y
);

  localparam logic NARROW = (COORD_WIDTH <= apbb_pkg::DATA_W);

  // a reset empties the result register
  `APBB_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // with no box waiting nothing may hold off the input
  `APBB_ASSERT(a_ready_idle, !out_valid |-> in_ready, "input stalled with empty output")

  // a waiting box keeps its corners until taken
  `APBB_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(min_x) && $stable(min_y) && $stable(max_x) && $stable(max_y)), "box changed while stalled")

  // the corners of a box are ordered when coordinates are no wider than the data word
  `APBB_ASSERT(a_box_order, (out_valid && NARROW) |-> (min_x <= max_x && min_y <= max_y), "box corners out of order")

  // the register port never inserts wait states
  `APBB_ASSERT(a_pready, in_valid || !in_valid |-> pready, "apb wait state seen")

endmodule

bind affine_point_bounding_box apbb_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_apbb_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .min_x     (min_x),
  .min_y     (min_y),
  .max_x     (max_x),
  .max_y     (max_y)
);

`default_nettype wire
